// ===== design/lbmq_pkg.sv =====
`timescale 1ns / 1ps
package lbmq_pkg;

	typedef enum logic [1:0] {
		MODE_PUSH_BEGIN = 2'd0,
		MODE_PUSH_BYTE  = 2'd1,
		MODE_POP_BEGIN  = 2'd2,
		MODE_POP_BYTE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_NOMEM  = 3'd2,
		ST_BADLEN = 3'd3,
		ST_SEQ    = 3'd4
	} status_t;

	localparam logic REG_BLOCK_DATA_BYTES = 1'b0;
	localparam logic REG_BLOCKS_IN_USE    = 1'b1;

	localparam logic [12:0] MAX_MSG_LEN = 13'd4096;
	localparam int          QUOT_W      = 14;

endpackage

// ===== design/linked_block_message_queue.sv =====
`timescale 1ns / 1ps
// Message queue kept in fixed-size blocks chained through a link memory, with a LIFO free list
// and a ring of queued messages. Each item is taken with start while busy is low. Its single
// result appears one cycle with done high; the receiver cannot stall it, so it must be
// taken in that cycle. Push byte, pop begin and pop byte read the state from the synchronous
// byte, link and ring memories when the item is taken and write it back in the next cycle.
// A push begin that passes its checks first goes through state S_DIV, where the block count
// ceil(length / block bytes) comes from a one-bit-per-cycle restoring divider. Errors of
// length, sequence or emptiness skip it; out of memory comes after it. Write the config only
// while idle (not enforced); a write re-initializes the queue at once, with no clearing pass.
module linked_block_message_queue
	import lbmq_pkg::*;
#(
	parameter int NUM_BLOCKS  = 64,
	parameter int BLOCK_BYTES = 64,
	parameter int RING_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [6:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic [12:0] msg_len,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  out_byte,
	output logic [12:0] out_len,
	output logic        last,
	output logic [6:0]  msg_count,
	output logic [6:0]  free_blocks
);

	localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int AW  = $clog2(NUM_BLOCKS * BLOCK_BYTES);
	localparam int RW  = $clog2(RING_DEPTH);
	localparam int CW  = $clog2(RING_DEPTH + 1);
	localparam int EW  = BW + 13;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_RD, S_RESP} state_t;

	function automatic logic [AW-1:0] blk_addr(input logic [BW-1:0] b, input logic [6:0] off);
		blk_addr = AW'(b) * AW'(BLOCK_BYTES) + AW'(off);
	endfunction

	function automatic logic [6:0] clamp_reg(input logic [6:0] v, input int hi);
		logic [6:0] r;
		r = v;
		if (v == 7'd0)
			r = 7'd1;
		else if (int'(v) > hi)
			r = 7'(hi);
		clamp_reg = r;
	endfunction

	logic [7:0]    blk_mem [NUM_BLOCKS*BLOCK_BYTES];
	logic [BW-1:0] link_mem [NUM_BLOCKS];
	logic [EW-1:0] ring_mem [RING_DEPTH];

	state_t        state_q;
	mode_t         mode_q;
	logic [7:0]    byte_q;
	logic [12:0]   len_q;
	logic [6:0]    bdb_q, biu_q;
	logic [NUM_BLOCKS-1:0] lvld_q;
	logic [BW-1:0] fh_q;
	logic [6:0]    fc_q;
	logic [RW-1:0] rd_q, wr_q;
	logic [CW-1:0] qc_q;

	logic          pu_open_q, pu_first_q;
	logic [12:0]   pu_rem_q, pu_len_q;
	logic [BW-1:0] pu_cur_q, pu_prev_q, pu_head_q;
	logic [6:0]    pu_off_q;

	logic          po_open_q;
	logic [12:0]   po_rem_q;
	logic [BW-1:0] po_cur_q;
	logic [6:0]    po_off_q;

	logic [QUOT_W-1:0] dvd_q;
	logic [7:0]        drem_q;
	logic [3:0]        dcnt_q;

	logic [7:0]    blk_s1;
	logic [BW-1:0] link_s1, ldef_s1;
	logic          lvld_s1;
	logic [EW-1:0] ring_s1;

	logic          accept;
	mode_t         mode_in;
	logic [BW-1:0] link_ra, pu_b, link_rd, link_wa, new_head;
	logic [AW-1:0] blk_ra;
	logic          blk_we, link_we, ring_we;
	logic [7:0]    pu_off_n, po_off_n;
	logic          po_end;
	logic [7:0]    drem_sh;
	logic          dge;
	logic [RW-1:0] rd_n, wr_n;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign mode_in = mode_t'(mode);

	assign link_ra = (mode_in == MODE_POP_BYTE) ? po_cur_q : fh_q;
	assign blk_ra  = blk_addr(po_cur_q, po_off_q);

	assign link_rd  = lvld_s1 ? link_s1 : ldef_s1;
	assign pu_b     = (pu_off_q == 7'd0) ? fh_q : pu_cur_q;
	assign new_head = (pu_off_q == 7'd0 && pu_first_q) ? fh_q : pu_head_q;
	assign pu_off_n = {1'b0, pu_off_q} + 8'd1;
	assign po_off_n = {1'b0, po_off_q} + 8'd1;
	assign po_end   = (po_off_n >= {1'b0, bdb_q}) || (po_rem_q == 13'd1);

	assign blk_we  = (state_q == S_RD) && (mode_q == MODE_PUSH_BYTE);
	assign ring_we = blk_we && (pu_rem_q == 13'd1);
	assign link_we = (blk_we && pu_off_q == 7'd0 && !pu_first_q) ||
		((state_q == S_RD) && (mode_q == MODE_POP_BYTE) && po_end);
	assign link_wa = (mode_q == MODE_PUSH_BYTE) ? pu_prev_q : po_cur_q;

	assign rd_n = (int'(rd_q) == RING_DEPTH - 1) ? '0 : rd_q + RW'(1);
	assign wr_n = (int'(wr_q) == RING_DEPTH - 1) ? '0 : wr_q + RW'(1);

	assign drem_sh = {drem_q[6:0], dvd_q[QUOT_W-1]};
	assign dge     = (drem_sh >= {1'b0, bdb_q});

	assign msg_count   = 7'(qc_q);
	assign free_blocks = fc_q;

	always_ff @(posedge clk) begin
		blk_s1  <= blk_mem[blk_ra];
		link_s1 <= link_mem[link_ra];
		ldef_s1 <= (int'(link_ra) == NUM_BLOCKS - 1) ? '0 : link_ra + BW'(1);
		ring_s1 <= ring_mem[rd_q];
		if (blk_we)
			blk_mem[blk_addr(pu_b, pu_off_q)] <= byte_q;
		if (link_we)
			link_mem[link_wa] <= fh_q;
		if (ring_we)
			ring_mem[wr_q] <= {new_head, pu_len_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_PUSH_BEGIN;
			byte_q     <= '0;
			len_q      <= '0;
			bdb_q      <= clamp_reg(7'd64, BLOCK_BYTES);
			biu_q      <= clamp_reg(7'd64, NUM_BLOCKS);
			lvld_q     <= '0;
			lvld_s1    <= 1'b0;
			fh_q       <= '0;
			fc_q       <= clamp_reg(7'd64, NUM_BLOCKS);
			rd_q       <= '0;
			wr_q       <= '0;
			qc_q       <= '0;
			pu_open_q  <= 1'b0;
			pu_first_q <= 1'b0;
			pu_rem_q   <= '0;
			pu_len_q   <= '0;
			pu_cur_q   <= '0;
			pu_prev_q  <= '0;
			pu_head_q  <= '0;
			pu_off_q   <= '0;
			po_open_q  <= 1'b0;
			po_rem_q   <= '0;
			po_cur_q   <= '0;
			po_off_q   <= '0;
			dvd_q      <= '0;
			drem_q     <= '0;
			dcnt_q     <= '0;
			done       <= 1'b0;
			status     <= ST_OK;
			out_byte   <= '0;
			out_len    <= '0;
			last       <= 1'b0;
		end else begin
			done    <= 1'b0;
			lvld_s1 <= lvld_q[link_ra];
			if (cfg_we) begin
				if (cfg_addr == REG_BLOCK_DATA_BYTES) begin
					bdb_q <= clamp_reg(cfg_wdata, BLOCK_BYTES);
					fc_q  <= biu_q;
				end else begin
					biu_q <= clamp_reg(cfg_wdata, NUM_BLOCKS);
					fc_q  <= clamp_reg(cfg_wdata, NUM_BLOCKS);
				end
				lvld_q    <= '0;
				fh_q      <= '0;
				rd_q      <= '0;
				wr_q      <= '0;
				qc_q      <= '0;
				pu_open_q <= 1'b0;
				po_open_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= mode_in;
						byte_q   <= data_byte;
						len_q    <= msg_len;
						status   <= ST_OK;
						out_byte <= '0;
						out_len  <= '0;
						last     <= 1'b0;
						state_q  <= S_RESP;
						case (mode_in)
							MODE_PUSH_BEGIN: begin
								if (pu_open_q)
									status <= ST_SEQ;
								else if (msg_len == 13'd0 || msg_len > MAX_MSG_LEN)
									status <= ST_BADLEN;
								else begin
									dvd_q   <= QUOT_W'(msg_len) + QUOT_W'(bdb_q) - QUOT_W'(1);
									drem_q  <= '0;
									dcnt_q  <= 4'(QUOT_W);
									state_q <= S_DIV;
								end
							end
							MODE_PUSH_BYTE: begin
								if (!pu_open_q)
									status <= ST_SEQ;
								else
									state_q <= S_RD;
							end
							MODE_POP_BEGIN: begin
								if (po_open_q)
									status <= ST_SEQ;
								else if (qc_q == '0)
									status <= ST_EMPTY;
								else
									state_q <= S_RD;
							end
							default: begin
								if (!po_open_q)
									status <= ST_SEQ;
								else
									state_q <= S_RD;
							end
						endcase
					end
				end
				S_DIV: begin
					dvd_q  <= {dvd_q[QUOT_W-2:0], dge};
					drem_q <= dge ? drem_sh - {1'b0, bdb_q} : drem_sh;
					dcnt_q <= dcnt_q - 4'd1;
					if (dcnt_q == 4'd0) begin
						if (dvd_q > QUOT_W'(fc_q) || int'(qc_q) >= RING_DEPTH)
							status <= ST_NOMEM;
						else begin
							fc_q       <= fc_q - 7'(dvd_q);
							pu_open_q  <= 1'b1;
							pu_rem_q   <= len_q;
							pu_len_q   <= len_q;
							pu_off_q   <= '0;
							pu_first_q <= 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_RD: begin
					state_q <= S_RESP;
					case (mode_q)
						MODE_PUSH_BYTE: begin
							if (pu_off_q == 7'd0) begin
								fh_q       <= link_rd;
								pu_first_q <= 1'b0;
								pu_cur_q   <= fh_q;
								pu_head_q  <= new_head;
								if (!pu_first_q)
									lvld_q[pu_prev_q] <= 1'b1;
							end
							pu_rem_q <= pu_rem_q - 13'd1;
							if (pu_off_n >= {1'b0, bdb_q}) begin
								pu_off_q  <= '0;
								pu_prev_q <= pu_b;
							end else
								pu_off_q <= 7'(pu_off_n);
							if (pu_rem_q == 13'd1) begin
								wr_q      <= wr_n;
								qc_q      <= qc_q + CW'(1);
								pu_open_q <= 1'b0;
								last      <= 1'b1;
							end
						end
						MODE_POP_BEGIN: begin
							po_cur_q  <= ring_s1[EW-1:13];
							po_rem_q  <= ring_s1[12:0];
							po_off_q  <= '0;
							po_open_q <= (ring_s1[12:0] != 13'd0);
							out_len   <= ring_s1[12:0];
							rd_q      <= rd_n;
							qc_q      <= qc_q - CW'(1);
						end
						MODE_POP_BYTE: begin
							out_byte <= blk_s1;
							po_rem_q <= po_rem_q - 13'd1;
							po_off_q <= 7'(po_off_n);
							if (po_end) begin
								lvld_q[po_cur_q] <= 1'b1;
								fh_q     <= po_cur_q;
								fc_q     <= fc_q + 7'd1;
								po_cur_q <= link_rd;
								po_off_q <= '0;
							end
							if (po_rem_q == 13'd1) begin
								po_open_q <= 1'b0;
								last      <= 1'b1;
							end
						end
						default: status <= ST_SEQ;
					endcase
				end
				S_RESP: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	assert property (@(posedge clk) disable iff (!arst_n) fc_q <= biu_q)
		else $error("free count above managed blocks");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && last) |-> (status == ST_OK))
		else $error("last marked on a refused item");
	assert property (@(posedge clk) disable iff (!arst_n) int'(qc_q) <= RING_DEPTH)
		else $error("ring count overflow");

endmodule

// ===== bench/lbmq_checker.sv =====
`timescale 1ns / 1ps
module lbmq_checker
	import lbmq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [6:0]  cfg_wdata,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic [12:0] msg_len,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [7:0]  out_byte,
	input  logic [12:0] out_len,
	input  logic        last,
	input  logic [6:0]  msg_count,
	input  logic [6:0]  free_blocks,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		status_t     st;
		logic [7:0]  byte_v;
		logic [12:0] len_v;
		logic        last_v;
		logic [6:0]  count_v;
		logic [6:0]  free_v;
	} outcome_t;

	typedef struct {
		bit   open;
		int   remaining;
		int   cur;
		int   prev;
		int   offset;
		int   head;
		int   len;
		bit   first;
	} cursor_t;

	outcome_t    expected_q[$];
	int          bytes_per_blk, blk_limit;
	logic [7:0]  payload [0:4095];
	int          link [0:63];
	int          ring_head [0:63];
	int          ring_len [0:63];
	int          free_top, free_cnt, rd_ptr, wr_ptr, queued;
	cursor_t     wr_cur, rd_cur;

	assign pending = expected_q.size();

	function automatic int clamp7(logic [6:0] v);
		if (v < 1) return 1;
		if (v > 64) return 64;
		return int'(v);
	endfunction

	task automatic clear_queue();
		for (int i = 0; i < 64; i++) link[i] = (i + 1 < 64) ? i + 1 : 0;
		free_top = 0;
		free_cnt = blk_limit;
		rd_ptr = 0;
		wr_ptr = 0;
		queued = 0;
		wr_cur = '{default: 0};
		rd_cur = '{default: 0};
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic outcome_t queue_step(mode_t m, logic [7:0] d, logic [12:0] l);
		outcome_t o;
		int need, b, nxt;
		o = '0;
		o.st = ST_OK;
		case (m)
			MODE_PUSH_BEGIN: begin
				if (wr_cur.open) o.st = ST_SEQ;
				else if (l == 0 || l > MAX_MSG_LEN) o.st = ST_BADLEN;
				else begin
					need = (int'(l) + bytes_per_blk - 1) / bytes_per_blk;
					if (need > free_cnt || queued >= 64) o.st = ST_NOMEM;
					else begin
						free_cnt -= need;
						wr_cur.open = 1;
						wr_cur.remaining = int'(l);
						wr_cur.len = int'(l);
						wr_cur.offset = 0;
						wr_cur.first = 1;
					end
				end
			end
			MODE_PUSH_BYTE: begin
				if (!wr_cur.open) o.st = ST_SEQ;
				else begin
					if (wr_cur.offset == 0) begin
						b = free_top;
						free_top = link[b];
						if (wr_cur.first) wr_cur.head = b;
						else link[wr_cur.prev] = b;
						wr_cur.first = 0;
						wr_cur.cur = b;
					end
					payload[wr_cur.cur * 64 + wr_cur.offset] = d;
					wr_cur.offset++;
					wr_cur.remaining--;
					if (wr_cur.offset >= bytes_per_blk) begin
						wr_cur.offset = 0;
						wr_cur.prev = wr_cur.cur;
					end
					if (wr_cur.remaining == 0) begin
						ring_head[wr_ptr] = wr_cur.head;
						ring_len[wr_ptr] = wr_cur.len;
						wr_ptr = (wr_ptr + 1) % 64;
						queued++;
						wr_cur.open = 0;
						o.last_v = 1;
					end
				end
			end
			MODE_POP_BEGIN: begin
				if (rd_cur.open) o.st = ST_SEQ;
				else if (queued == 0) o.st = ST_EMPTY;
				else begin
					rd_cur.open = 1;
					rd_cur.cur = ring_head[rd_ptr];
					rd_cur.len = ring_len[rd_ptr];
					rd_cur.remaining = ring_len[rd_ptr];
					rd_cur.offset = 0;
					rd_ptr = (rd_ptr + 1) % 64;
					queued--;
					o.len_v = 13'(rd_cur.len);
				end
			end
			default: begin
				if (!rd_cur.open) o.st = ST_SEQ;
				else begin
					b = rd_cur.cur;
					o.byte_v = payload[b * 64 + rd_cur.offset];
					rd_cur.offset++;
					rd_cur.remaining--;
					if (rd_cur.offset >= bytes_per_blk || rd_cur.remaining == 0) begin
						nxt = link[b];
						link[b] = free_top;
						free_top = b;
						free_cnt++;
						rd_cur.cur = nxt;
						rd_cur.offset = 0;
					end
					if (rd_cur.remaining == 0) begin
						rd_cur.open = 0;
						o.last_v = 1;
					end
				end
			end
		endcase
		o.count_v = 7'(queued);
		o.free_v = 7'(free_cnt);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t w;
		if (!arst_n) begin
			fail_count = 0;
			expected_q.delete();
			bytes_per_blk = 64;
			blk_limit = 64;
			clear_queue();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					fail_count++;
				end else begin
					w = expected_q.pop_front();
					if (status !== w.st) report("status", 32'(status), 32'(w.st));
					if (out_byte !== w.byte_v)
						report("out_byte", 32'(out_byte), 32'(w.byte_v));
					if (out_len !== w.len_v) report("out_len", 32'(out_len), 32'(w.len_v));
					if (last !== w.last_v) report("last", 32'(last), 32'(w.last_v));
					if (msg_count !== w.count_v)
						report("msg_count", 32'(msg_count), 32'(w.count_v));
					if (free_blocks !== w.free_v)
						report("free_blocks", 32'(free_blocks), 32'(w.free_v));
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_BLOCK_DATA_BYTES) bytes_per_blk = clamp7(cfg_wdata);
				else blk_limit = clamp7(cfg_wdata);
				clear_queue();
			end
			if (start && !busy)
				expected_q.push_back(queue_step(mode_t'(mode), data_byte, msg_len));
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb
	import lbmq_pkg::*;
();

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_addr = 0;
	logic [6:0]  cfg_wdata = 0;
	logic        start = 0;
	logic [1:0]  mode = 0;
	logic [7:0]  data_byte = 0;
	logic [12:0] msg_len = 0;
	logic        busy, done, last;
	logic [2:0]  status;
	logic [7:0]  out_byte;
	logic [12:0] out_len;
	logic [6:0]  msg_count, free_blocks;
	int          fail_count, pending, idle_cycles;
	int          sent;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	linked_block_message_queue dut (.*);

	lbmq_checker chk (.*);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send(mode_t m, logic [7:0] d, logic [12:0] l);
		int gap;
		@(negedge clk);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		start <= 1;
		mode <= m;
		data_byte <= d;
		msg_len <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start <= 0;
		sent++;
	endtask

	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic a, logic [6:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= a;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic push_msg(int n, bit wild);
		send(MODE_PUSH_BEGIN, 8'($urandom), 13'(n));
		for (int i = 0; i < n; i++)
			send(MODE_PUSH_BYTE, wild ? 8'(255 * (i % 2)) : 8'($urandom), 13'd0);
	endtask

	task automatic pop_msg(int n);
		send(MODE_POP_BEGIN, 8'($urandom), 13'($urandom));
		for (int i = 0; i < n; i++) send(MODE_POP_BYTE, 8'($urandom), 13'($urandom));
	endtask

	task automatic random_phase(int items);
		int r, n;
		int goal;
		goal = sent + items;
		while (sent < goal) begin
			r = $urandom_range(0, 9);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 12);
			if (r < 4) push_msg(n, 0);
			else if (r < 8) pop_msg($urandom_range(0, 14));
			else send(mode_t'($urandom_range(0, 3)), 8'($urandom), 13'($urandom));
		end
	endtask

	initial begin
		sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send(MODE_POP_BEGIN, 0, 0);
		send(MODE_POP_BYTE, 0, 0);
		send(MODE_PUSH_BYTE, 8'hff, 0);
		send(MODE_PUSH_BEGIN, 0, 0);
		send(MODE_PUSH_BEGIN, 0, 13'h1fff);
		send(MODE_PUSH_BEGIN, 0, 4097);
		send(MODE_PUSH_BEGIN, 0, 4096);
		send(MODE_PUSH_BEGIN, 0, 2);
		send(MODE_PUSH_BYTE, 8'h00, 0);
		send(MODE_PUSH_BEGIN, 0, 3);
		send(MODE_PUSH_BYTE, 8'hff, 0);
		send(MODE_PUSH_BYTE, 8'h5a, 13'h1fff);
		send(MODE_POP_BEGIN, 0, 0);
		send(MODE_POP_BEGIN, 0, 0);
		send(MODE_POP_BYTE, 0, 0);
		send(MODE_POP_BYTE, 0, 0);
		send(MODE_POP_BYTE, 0, 0);
		write_reg(REG_BLOCK_DATA_BYTES, 1);
		write_reg(REG_BLOCKS_IN_USE, 2);
		push_msg(2, 1);
		send(MODE_PUSH_BEGIN, 0, 1);
		pop_msg(2);
		random_phase(40);
		write_reg(REG_BLOCKS_IN_USE, 0);
		random_phase(30);
		write_reg(REG_BLOCK_DATA_BYTES, 7'h7f);
		write_reg(REG_BLOCKS_IN_USE, 7'h7f);
		random_phase(60);
		write_reg(REG_BLOCK_DATA_BYTES, 0);
		write_reg(REG_BLOCKS_IN_USE, 64);
		for (int i = 0; i < 65; i++) push_msg(1, 1);
		random_phase(30);
		write_reg(REG_BLOCK_DATA_BYTES, 5);
		write_reg(REG_BLOCKS_IN_USE, 9);
		random_phase(60);
		write_reg(REG_BLOCK_DATA_BYTES, 64);
		write_reg(REG_BLOCKS_IN_USE, 64);
		random_phase(40);
		settle();
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
